@@ src/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared sizes, configuration struct and null marker for the buddy allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int UNITS  = 1024;
    localparam int LEVELS = 11;
    localparam int OW     = $clog2(UNITS);
    localparam int NW     = OW + 1;
    localparam int LW     = 4;
    localparam int HALF   = UNITS / 2;
    localparam int PDEPTH = LEVELS * HALF;
    localparam int AW     = $clog2(PDEPTH);
    localparam int LVW    = $clog2(LEVELS);
    localparam int PL_W   = 11;
    localparam int CFG_AW = 3;
    localparam int DW     = 32;

    localparam logic [NW-1:0] NIL = NW'(UNITS);

    // effective configuration, clamped to the store sizes
    typedef struct packed {
        logic [NW-1:0] pool;
        logic [LW-1:0] top;
    } t_cfg;

endpackage

@@ src/bba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/bba_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cfg
// apb register file: pool size and top level, with clamped copies
// ----------------------------------------------------------------------------
module bba_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bba_pkg::CFG_AW-1:0] paddr,
    input  logic [bba_pkg::DW-1:0]    pwdata,
    output logic [bba_pkg::DW-1:0]    prdata,
    output logic                      pready,
    output bba_pkg::t_cfg             o_cfg
);
    import bba_pkg::*;

    localparam logic R_POOL = 1'b0;

    logic [PL_W-1:0] r_pool_units;
    logic [LW-1:0]   r_top_level;
    logic            wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_units <= PL_W'(UNITS);
            r_top_level  <= LW'(LEVELS - 1);
        end else if (wr) begin
            if (paddr[2] == R_POOL) begin
                r_pool_units <= pwdata[PL_W-1:0];
            end else begin
                r_top_level <= pwdata[LW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == R_POOL) ? DW'(r_pool_units) : DW'(r_top_level);

    // clamp out-of-range values
    assign o_cfg.pool = (r_pool_units > PL_W'(UNITS)) ? NW'(UNITS) : NW'(r_pool_units);
    assign o_cfg.top  = (r_top_level > LW'(LEVELS - 1)) ? LW'(LEVELS - 1) : r_top_level;
endmodule

@@ src/buddy_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator with per-level lifo free lists and per-level pair bitmaps
// ----------------------------------------------------------------------------
//  channel   signals                                         handshake
//  command   start, i_cmd, i_level, i_offset                  start && !busy
//  result    o_done, o_status, o_block_offset, o_block_level  o_done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata             apb, pready tied high
//
//  one item at a time; busy is high from acceptance until the result strobe
//  allocate scans upward for a non-empty list, pops it, then splits down
//  pushing upper halves; free and query walk the link store one link at
//  a time, free with a pair bit read-modify-write per merge level
//  initialise and reset run a clearing pass over all LEVELS*UNITS/2
//  (5632 here) pair ram entries, then initialise tiles the pool
//  the receiver cannot stall: each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_cmd,
    input  logic [bba_pkg::LW-1:0]     i_level,
    input  logic [bba_pkg::OW-1:0]     i_offset,
    output logic                       o_done,
    output logic                       o_status,
    output logic [bba_pkg::OW-1:0]     o_block_offset,
    output logic [bba_pkg::LW-1:0]     o_block_level,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bba_pkg::CFG_AW-1:0] paddr,
    input  logic [bba_pkg::DW-1:0]     pwdata,
    output logic [bba_pkg::DW-1:0]     prdata,
    output logic                       pready
);
    import bba_pkg::*;

    // command codes
    localparam logic [1:0] C_INIT  = 2'd0;
    localparam logic [1:0] C_ALLOC = 2'd1;
    localparam logic [1:0] C_FREE  = 2'd2;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLR      = 5'd1;
    localparam logic [4:0] S_INIT_REM = 5'd2;
    localparam logic [4:0] S_INIT_INC = 5'd3;
    localparam logic [4:0] S_INIT_TOP = 5'd4;
    localparam logic [4:0] S_PUSH     = 5'd5;
    localparam logic [4:0] S_PRD      = 5'd6;
    localparam logic [4:0] S_PWR      = 5'd7;
    localparam logic [4:0] S_A_POP    = 5'd8;
    localparam logic [4:0] S_A_POP2   = 5'd9;
    localparam logic [4:0] S_A_SPLIT  = 5'd10;
    localparam logic [4:0] S_A_DONE   = 5'd11;
    localparam logic [4:0] S_F_CHK    = 5'd12;
    localparam logic [4:0] S_F_CHK2   = 5'd13;
    localparam logic [4:0] S_F_MERGE  = 5'd14;
    localparam logic [4:0] S_F_DONE   = 5'd15;
    localparam logic [4:0] S_Q_RD     = 5'd16;
    localparam logic [4:0] S_Q_CHK    = 5'd17;
    localparam logic [4:0] S_W_TEST   = 5'd18;
    localparam logic [4:0] S_W_NEXT   = 5'd19;
    localparam logic [4:0] S_W_END    = 5'd20;

    // pair ram address: one row of HALF pairs per level
    function automatic logic [AW-1:0] pair_at(input logic [LW-1:0] e,
                                              input logic [NW-1:0] b);
        logic [NW-1:0] s;
        s = b >> ({1'b0, e} + 5'd1);
        return AW'(int'(e) * HALF) + AW'(s);
    endfunction

    function automatic logic aligned(input logic [OW-1:0] off, input logic [LW-1:0] e);
        logic [OW-1:0] m;
        m = ~({OW{1'b1}} << e);
        return (off & m) == '0;
    endfunction

    t_cfg cfg;

    bba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // link store, indexed by block start
    logic          link_we;
    logic [OW-1:0] link_addr;
    logic [NW-1:0] link_wd, link_rd;

    bba_ram #(.W(NW), .D(UNITS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_addr  (link_addr),
        .i_wdata (link_wd),
        .o_rdata (link_rd)
    );

    // pair bits: bit 1 alloc, bit 0 free
    logic          pair_we;
    logic [AW-1:0] pair_addr;
    logic [1:0]    pair_wd, pair_rd;

    bba_ram #(.W(2), .D(PDEPTH)) u_pair (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_addr  (pair_addr),
        .i_wdata (pair_wd),
        .o_rdata (pair_rd)
    );

    logic [4:0]    r_state, n_state, r_ret, n_ret;
    logic [LW-1:0] r_lvl, n_lvl, r_e, n_e;
    logic [OW-1:0] r_mem, n_mem;
    logic [NW-1:0] r_b, n_b, r_pb, n_pb, r_off, n_off;
    logic [NW-1:0] r_t, n_t, r_p, n_p, r_prev, n_prev, r_n, n_n;
    logic [AW-1:0] r_paddr, n_paddr, r_cnt, n_cnt;
    logic          r_tog, n_tog, r_aset, n_aset, r_aval, n_aval;
    logic          r_found, n_found, r_isq, n_isq, r_init, n_init;
    logic          r_done, n_done, r_status, n_status;
    logic [OW-1:0] r_ro, n_ro;
    logic [LW-1:0] r_rl, n_rl;
    logic [NW-1:0] r_head [LEVELS];

    logic          head_we, head_clr;
    logic [NW-1:0] head_val, hb, bit_e, bit_em1, topsz;
    logic          acc, fin, fin_st;
    logic [OW-1:0] fin_ro;
    logic [LW-1:0] fin_rl;

    assign busy    = (r_state != S_IDLE);
    assign acc     = start && !busy;
    assign hb      = r_head[LVW'(r_e)];
    assign bit_e   = NW'(1) << r_e;
    assign bit_em1 = NW'(1) << (r_e - LW'(1));
    assign topsz   = NW'(1) << cfg.top;

    always_comb begin
        n_state = r_state;  n_ret  = r_ret;   n_lvl   = r_lvl;   n_e    = r_e;
        n_mem   = r_mem;    n_b    = r_b;     n_pb    = r_pb;    n_off  = r_off;
        n_t     = r_t;      n_p    = r_p;     n_prev  = r_prev;  n_n    = r_n;
        n_paddr = r_paddr;  n_cnt  = r_cnt;   n_tog   = r_tog;   n_aset = r_aset;
        n_aval  = r_aval;   n_found = r_found; n_isq  = r_isq;   n_init = r_init;
        n_status = r_status; n_ro  = r_ro;    n_rl    = r_rl;    n_done = 1'b0;
        head_we = 1'b0;  head_clr = 1'b0;  head_val = NIL;
        link_we = 1'b0;  link_addr = r_p[OW-1:0];  link_wd = NIL;
        pair_we = 1'b0;  pair_addr = r_paddr;      pair_wd = 2'b00;
        fin = 1'b0;  fin_st = 1'b1;  fin_ro = '0;  fin_rl = '0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_lvl = i_level;
                    n_mem = i_offset;
                    case (i_cmd)
                        C_INIT: begin
                            head_clr = 1'b1;
                            n_init   = 1'b1;
                            n_cnt    = '0;
                            n_state  = S_CLR;
                        end
                        C_ALLOC: begin
                            if (i_level > cfg.top) begin
                                fin = 1'b1;
                            end else begin
                                n_e     = i_level;
                                n_state = S_A_POP;
                            end
                        end
                        C_FREE: begin
                            if (i_level <= cfg.top && {1'b0, i_offset} < cfg.pool
                                && aligned(i_offset, i_level)) begin
                                n_e     = i_level;
                                n_state = S_F_CHK;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            if ({1'b0, i_offset} < cfg.pool) begin
                                n_e     = '0;
                                n_state = S_Q_RD;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // clearing pass over the pair bits
            S_CLR: begin
                pair_we   = 1'b1;
                pair_addr = r_cnt;
                if (r_cnt == AW'(PDEPTH - 1)) begin
                    if (r_init) begin
                        n_e     = '0;
                        n_off   = cfg.pool;
                        n_state = S_INIT_REM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            // remainder blocks, smallest at the top of the pool
            S_INIT_REM: begin
                if (r_e < cfg.top) begin
                    if (cfg.pool[r_e]) begin
                        n_off   = r_off - bit_e;
                        n_pb    = r_off - bit_e;
                        n_ret   = S_INIT_INC;
                        n_state = S_PUSH;
                    end else begin
                        n_e = r_e + LW'(1);
                    end
                end else begin
                    n_e     = cfg.top;
                    n_state = S_INIT_TOP;
                end
            end

            S_INIT_INC: begin
                n_e     = r_e + LW'(1);
                n_state = S_INIT_REM;
            end

            S_INIT_TOP: begin
                if (r_off >= topsz) begin
                    n_off   = r_off - topsz;
                    n_pb    = r_off - topsz;
                    n_ret   = S_INIT_TOP;
                    n_state = S_PUSH;
                end else begin
                    n_init = 1'b0;
                    fin    = 1'b1;
                    fin_st = 1'b0;
                end
            end

            // push r_pb on list r_e, then toggle its free bit
            S_PUSH: begin
                if (r_pb >= NIL) begin
                    n_state = r_ret;
                end else begin
                    link_we   = 1'b1;
                    link_addr = r_pb[OW-1:0];
                    link_wd   = hb;
                    head_we   = 1'b1;
                    head_val  = r_pb;
                    n_paddr   = pair_at(r_e, r_pb);
                    n_tog     = 1'b1;
                    n_aset    = 1'b0;
                    n_state   = S_PRD;
                end
            end

            // pair bit read-modify-write
            S_PRD: begin
                n_state = S_PWR;
            end

            S_PWR: begin
                pair_we = 1'b1;
                pair_wd = {r_aset ? r_aval : pair_rd[1], pair_rd[0] ^ r_tog};
                n_state = r_ret;
            end

            // scan upwards for a non-empty list
            S_A_POP: begin
                if (hb < NIL) begin
                    link_addr = hb[OW-1:0];
                    n_b       = hb;
                    n_paddr   = pair_at(r_e, hb);
                    n_state   = S_A_POP2;
                end else if (r_e < cfg.top) begin
                    n_e = r_e + LW'(1);
                end else begin
                    fin = 1'b1;
                end
            end

            S_A_POP2: begin
                head_we  = 1'b1;
                head_val = link_rd;
                n_tog    = 1'b1;
                n_aset   = 1'b0;
                n_ret    = S_A_SPLIT;
                n_state  = S_PRD;
            end

            // split down, pushing upper halves
            S_A_SPLIT: begin
                if (r_e > r_lvl) begin
                    n_e     = r_e - LW'(1);
                    n_pb    = r_b + bit_em1;
                    n_ret   = S_A_SPLIT;
                    n_state = S_PUSH;
                end else begin
                    n_paddr = pair_at(r_lvl, r_b);
                    n_tog   = 1'b0;
                    n_aset  = 1'b1;
                    n_aval  = 1'b1;
                    n_ret   = S_A_DONE;
                    n_state = S_PRD;
                end
            end

            S_A_DONE: begin
                fin    = 1'b1;
                fin_st = 1'b0;
                fin_ro = r_b[OW-1:0];
                fin_rl = r_lvl;
            end

            // merge with free buddies below the top level
            S_F_CHK: begin
                if (r_e < cfg.top) begin
                    pair_addr = pair_at(r_e, {1'b0, r_mem});
                    n_state   = S_F_CHK2;
                end else begin
                    n_pb    = {1'b0, r_mem};
                    n_ret   = S_F_DONE;
                    n_state = S_PUSH;
                end
            end

            S_F_CHK2: begin
                if (pair_rd[0]) begin
                    n_t     = {1'b0, r_mem ^ bit_e[OW-1:0]};
                    n_p     = hb;
                    n_prev  = NIL;
                    n_n     = '0;
                    n_found = 1'b0;
                    n_isq   = 1'b0;
                    n_state = S_W_TEST;
                end else begin
                    n_pb    = {1'b0, r_mem};
                    n_ret   = S_F_DONE;
                    n_state = S_PUSH;
                end
            end

            S_F_MERGE: begin
                n_mem   = r_mem & ~bit_e[OW-1:0];
                n_e     = r_e + LW'(1);
                n_state = S_F_CHK;
            end

            S_F_DONE: begin
                fin    = 1'b1;
                fin_st = 1'b0;
                fin_ro = r_mem;
                fin_rl = r_e;
            end

            // size query: climb until a pair bit is set
            S_Q_RD: begin
                if (r_e <= cfg.top) begin
                    pair_addr = pair_at(r_e, {1'b0, r_mem});
                    n_state   = S_Q_CHK;
                end else begin
                    fin = 1'b1;
                end
            end

            S_Q_CHK: begin
                if (pair_rd[1]) begin
                    if (aligned(r_mem, r_e)) begin
                        n_t     = {1'b0, r_mem};
                        n_p     = hb;
                        n_prev  = NIL;
                        n_n     = '0;
                        n_found = 1'b0;
                        n_isq   = 1'b1;
                        n_state = S_W_TEST;
                    end else begin
                        fin = 1'b1;
                    end
                end else if (pair_rd[0]) begin
                    fin = 1'b1;
                end else begin
                    n_e     = r_e + LW'(1);
                    n_state = S_Q_RD;
                end
            end

            // list walk, bounded by UNITS links
            S_W_TEST: begin
                if (r_n < NIL && r_p < NIL) begin
                    link_addr = r_p[OW-1:0];
                    n_state   = S_W_NEXT;
                end else begin
                    n_state = S_W_END;
                end
            end

            S_W_NEXT: begin
                if (r_p == r_t) begin
                    n_found = 1'b1;
                    if (!r_isq) begin
                        if (r_prev == NIL) begin
                            head_we  = 1'b1;
                            head_val = link_rd;
                        end else begin
                            link_we   = 1'b1;
                            link_addr = r_prev[OW-1:0];
                            link_wd   = link_rd;
                        end
                    end
                    n_state = S_W_END;
                end else begin
                    n_prev  = r_p;
                    n_p     = link_rd;
                    n_n     = r_n + NW'(1);
                    n_state = S_W_TEST;
                end
            end

            S_W_END: begin
                if (r_isq) begin
                    fin    = 1'b1;
                    fin_st = r_found;
                    fin_ro = r_found ? '0 : r_mem;
                    fin_rl = r_found ? '0 : r_e;
                end else begin
                    // free bit toggles only if the buddy was unlinked
                    n_paddr = pair_at(r_e, {1'b0, r_mem});
                    n_tog   = r_found;
                    n_aset  = 1'b1;
                    n_aval  = 1'b0;
                    n_ret   = S_F_MERGE;
                    n_state = S_PRD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state  = S_IDLE;
            n_done   = 1'b1;
            n_status = fin_st;
            n_ro     = fin_ro;
            n_rl     = fin_rl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_init  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || head_clr) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= NIL;
            end
        end else if (head_we) begin
            r_head[LVW'(r_e)] <= head_val;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;    r_lvl  <= n_lvl;   r_e     <= n_e;     r_mem  <= n_mem;
        r_b      <= n_b;      r_pb   <= n_pb;    r_off   <= n_off;   r_t    <= n_t;
        r_p      <= n_p;      r_prev <= n_prev;  r_n     <= n_n;     r_paddr <= n_paddr;
        r_tog    <= n_tog;    r_aset <= n_aset;  r_aval  <= n_aval;  r_found <= n_found;
        r_isq    <= n_isq;    r_status <= n_status; r_ro <= n_ro;    r_rl   <= n_rl;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_block_offset = r_ro;
    assign o_block_level  = r_rl;

    // the strobe only comes when the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    // an accepted item either starts work or fails at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done)) else $error("accepted item did not start");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_block_offset == '0 && o_block_level == '0))
        else $error("failure result carries a block");
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the buddy block allocator: a directed table with
// hand-typed results for the obvious cases, then random allocate/free/query
// traffic under several pool settings; untyped items are checked against an in-bench
// model of the free lists and pair bitmaps
// ----------------------------------------------------------------------------
module tb_top;
    import bba_pkg::*;

    // command codes on i_cmd
    typedef enum logic [1:0] {CMD_INIT, CMD_ALLOC, CMD_FREE, CMD_QUERY} t_cmd;

    // register byte addresses on the apb port
    localparam logic [CFG_AW-1:0] REG_POOL = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TOP  = 3'd4;

    localparam int PAIRS      = UNITS / 2 + 1;
    // generous: two clearing passes plus the longest list walks with merges
    localparam int STALL_MAX  = 200000;
    localparam int RAND_ITEMS = 90;

    typedef struct packed {
        logic          status;
        logic [OW-1:0] offset;
        logic [LW-1:0] level;
    } t_outcome;

    typedef struct {
        t_cmd     cmd;
        int       lvl;
        int       off;
        bit       typed;
        t_outcome want;
    } t_row;

    typedef struct {
        int off;
        int lvl;
    } t_block;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    i_cmd = '0;
    logic [LW-1:0] i_level = '0;
    logic [OW-1:0] i_offset = '0;
    logic          o_done, o_status;
    logic [OW-1:0] o_block_offset;
    logic [LW-1:0] o_block_level;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [DW-1:0] pwdata = '0;
    logic [DW-1:0] prdata;
    logic          pready;

    buddy_block_allocator i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // allocator model: lifo lists per level, link store, pair bitmaps
    // ------------------------------------------------------------------
    logic [10:0] cfg_pool;
    logic [3:0]  cfg_top;
    int          head_of[LEVELS];
    int          link_of[UNITS];
    bit          pair_free[LEVELS][PAIRS];
    bit          pair_used[LEVELS][PAIRS];

    function automatic int pool_eff();
        return (cfg_pool > UNITS) ? UNITS : int'(cfg_pool);
    endfunction

    function automatic int top_eff();
        return (cfg_top > LEVELS - 1) ? LEVELS - 1 : int'(cfg_top);
    endfunction

    function automatic void wipe_lists();
        foreach (head_of[e]) head_of[e] = UNITS;
        foreach (link_of[i]) link_of[i] = 0;
        foreach (pair_free[e, p]) begin
            pair_free[e][p] = 1'b0;
            pair_used[e][p] = 1'b0;
        end
    endfunction

    function automatic void list_push(int e, int b);
        if (b >= UNITS) return;
        link_of[b] = head_of[e];
        head_of[e] = b;
        pair_free[e][b >> (e + 1)] ^= 1'b1;
    endfunction

    function automatic int list_pop(int e);
        int b;
        b = head_of[e];
        if (b >= UNITS) return UNITS;
        head_of[e] = link_of[b];
        pair_free[e][b >> (e + 1)] ^= 1'b1;
        return b;
    endfunction

    // unlink a buddy; walks are capped so a misuse cycle cannot hang
    function automatic void list_unlink(int e, int b);
        int prev, p;
        prev = UNITS;
        p = head_of[e];
        for (int n = 0; n < UNITS && p < UNITS; n++) begin
            if (p == b) begin
                if (prev == UNITS) head_of[e] = link_of[p];
                else link_of[prev] = link_of[p];
                pair_free[e][b >> (e + 1)] ^= 1'b1;
                return;
            end
            prev = p;
            p = link_of[p];
        end
    endfunction

    function automatic bit listed(int e, int b);
        int p;
        p = head_of[e];
        for (int n = 0; n < UNITS && p < UNITS; n++) begin
            if (p == b) return 1'b1;
            p = link_of[p];
        end
        return 1'b0;
    endfunction

    function automatic t_outcome allocator_next(t_cmd cmd, int lvl, int off);
        t_outcome r;
        int top, pool, k, b, e, rem, pos;
        r = '{status: 1'b1, offset: '0, level: '0};
        top = top_eff();
        pool = pool_eff();
        case (cmd)
            CMD_INIT: begin
                wipe_lists();
                rem = pool & ((1 << top) - 1);
                pos = pool;
                for (e = 0; e < top; e++)
                    if (rem & (1 << e)) begin
                        pos -= 1 << e;
                        list_push(e, pos);
                    end
                while (pos >= (1 << top)) begin
                    pos -= 1 << top;
                    list_push(top, pos);
                end
                r.status = 1'b0;
            end
            CMD_ALLOC: if (lvl <= top) begin
                b = UNITS;
                for (k = lvl; k <= top; k++) begin
                    b = list_pop(k);
                    if (b != UNITS) break;
                end
                if (b != UNITS) begin
                    // upper halves go back on the lists on the way down
                    while (k > lvl) begin
                        k--;
                        list_push(k, b + (1 << k));
                    end
                    pair_used[lvl][b >> (lvl + 1)] = 1'b1;
                    r = '{status: 1'b0, offset: OW'(b), level: LW'(lvl)};
                end
            end
            CMD_FREE: if (lvl <= top && off < pool && (off & ((1 << lvl) - 1)) == 0) begin
                e = lvl;
                while (e < top && pair_free[e][off >> (e + 1)]) begin
                    list_unlink(e, off ^ (1 << e));
                    pair_used[e][off >> (e + 1)] = 1'b0;
                    off &= ~(1 << e);
                    e++;
                end
                list_push(e, off);
                r = '{status: 1'b0, offset: OW'(off), level: LW'(e)};
            end
            default: if (off < pool) begin
                for (e = 0; e <= top; e++) begin
                    if (pair_used[e][off >> (e + 1)]) begin
                        if ((off & ((1 << e) - 1)) == 0 && !listed(e, off))
                            r = '{status: 1'b0, offset: OW'(off), level: LW'(e)};
                        break;
                    end
                    if (pair_free[e][off >> (e + 1)]) break;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // expected outcomes, checking and watchdog
    // ------------------------------------------------------------------
    t_outcome pending_outcomes[$];
    t_block   live_blocks[$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       calm = 1'b0;

    always @(posedge i_clk) begin
        t_outcome seen, want;
        if (i_rst_n && o_done) begin
            seen = '{status: o_status, offset: o_block_offset, level: o_block_level};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d offset %0d level %0d",
                             seen.status, seen.offset, seen.level);
            end else begin
                want = pending_outcomes.pop_front();
                if (seen != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.offset, want.level,
                                 seen.status, seen.offset, seen.level);
                end
            end
        end
    end

    // stalls are measured as cycles where neither an item nor a result moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic apb_write(logic [CFG_AW-1:0] addr, logic [DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_POOL) cfg_pool = data[10:0];
        else cfg_top = data[3:0];
    endtask

    // returns with start still high; a gap in the next call or drain lowers it
    task automatic issue(t_row row);
        t_outcome predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= row.cmd;
        i_level <= LW'(row.lvl);
        i_offset <= OW'(row.off);
        do @(posedge i_clk); while (busy);
        predicted = allocator_next(row.cmd, row.lvl, row.off);
        if (row.typed) predicted = row.want;
        pending_outcomes.push_back(predicted);
        if (row.cmd == CMD_ALLOC && predicted.status == 1'b0)
            live_blocks.push_back('{off: int'(predicted.offset), lvl: row.lvl});
        if (row.cmd == CMD_INIT) live_blocks.delete();
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_row plain(t_cmd c, int l, int o);
        return '{cmd: c, lvl: l, off: o, typed: 1'b0, want: '0};
    endfunction

    function automatic t_row typed(t_cmd c, int l, int o, bit s, int bo, int bl);
        return '{cmd: c, lvl: l, off: o, typed: 1'b1,
                 want: '{status: s, offset: OW'(bo), level: LW'(bl)}};
    endfunction

    // mostly well-formed traffic on live blocks, some noise on top
    task automatic random_phase(int items);
        int   pick, sel, top;
        t_row row;
        top = top_eff();
        issue(plain(CMD_INIT, 0, 0));
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || live_blocks.size() == 0) begin
                row = plain(CMD_ALLOC, ($urandom_range(0, 4) == 0) ?
                            $urandom_range(0, top) : $urandom_range(0, (top < 3) ? top : 3), 0);
            end else if (pick < 70) begin
                sel = $urandom_range(0, live_blocks.size() - 1);
                row = plain(CMD_FREE, live_blocks[sel].lvl, live_blocks[sel].off);
                live_blocks.delete(sel);
            end else if (pick < 85) begin
                sel = $urandom_range(0, live_blocks.size() - 1);
                row = plain(CMD_QUERY, $urandom_range(0, 15),
                            live_blocks[sel].off + $urandom_range(0, 1));
            end else if (pick < 97) begin
                row = plain(t_cmd'($urandom_range(1, 3)), $urandom_range(0, 15),
                            $urandom_range(0, 1023));
            end else begin
                row = plain(CMD_INIT, 0, 0);
            end
            issue(row);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // directed table, default pool of 1024 units and top level 10
    // ------------------------------------------------------------------
    t_row opening[$] = '{
        typed(CMD_ALLOC, 0, 0, 1, 0, 0),      // nothing tiled before init
        typed(CMD_QUERY, 0, 0, 1, 0, 0),
        typed(CMD_INIT, 0, 0, 0, 0, 0),
        typed(CMD_ALLOC, 10, 0, 0, 0, 10),    // whole pool in one block
        typed(CMD_ALLOC, 0, 0, 1, 0, 0),      // pool exhausted
        typed(CMD_QUERY, 0, 0, 0, 0, 10),
        typed(CMD_FREE, 10, 0, 0, 0, 10),
        typed(CMD_ALLOC, 0, 0, 0, 0, 0),      // split all the way down
        plain(CMD_ALLOC, 0, 0),
        plain(CMD_QUERY, 0, 1),
        plain(CMD_QUERY, 0, 3),               // inside a free block
        plain(CMD_ALLOC, 3, 0),
        plain(CMD_QUERY, 0, 12),              // middle of a block
        typed(CMD_ALLOC, 11, 0, 1, 0, 0),     // level above top
        typed(CMD_ALLOC, 15, 0, 1, 0, 0),
        typed(CMD_FREE, 15, 0, 1, 0, 0),
        typed(CMD_FREE, 1, 1, 1, 0, 0),       // misaligned free
        plain(CMD_FREE, 3, 8),
        plain(CMD_FREE, 0, 0),
        plain(CMD_FREE, 0, 1),                // merges back to the top
        plain(CMD_FREE, 0, 1023),             // trusted stray free
        plain(CMD_QUERY, 9, 1023),
        typed(CMD_INIT, 0, 0, 0, 0, 0)
    };

    initial begin
        cfg_pool = 11'd1024;
        cfg_top = 4'd10;
        wipe_lists();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[i]) issue(opening[i]);
        drain();

        // odd pool with remainder blocks at a mid top level
        apb_write(REG_POOL, 32'd1000);
        apb_write(REG_TOP, 32'd7);
        random_phase(RAND_ITEMS);
        // single unit, top level 0: nothing ever merges
        apb_write(REG_POOL, 32'd1);
        apb_write(REG_TOP, 32'd0);
        random_phase(RAND_ITEMS / 2);
        // empty pool, and top level beyond the store, which clamps
        apb_write(REG_POOL, 32'd0);
        apb_write(REG_TOP, 32'd15);
        random_phase(RAND_ITEMS / 3);
        apb_write(REG_POOL, 32'd2047);
        random_phase(RAND_ITEMS);
        apb_write(REG_POOL, 32'd37);
        apb_write(REG_TOP, 32'd3);
        random_phase(RAND_ITEMS);
        apb_write(REG_POOL, $urandom_range(1, 1024));
        apb_write(REG_TOP, $urandom_range(0, 10));
        random_phase(RAND_ITEMS);
        // closing stretch at full rate on the reset settings
        apb_write(REG_POOL, 32'd1024);
        apb_write(REG_TOP, 32'd10);
        calm = 1'b1;
        random_phase(RAND_ITEMS);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
